### src/gtfr_pkg.sv
// Shared types and constants for the glyph text field renderer.
// No dependencies; compile first.
`default_nettype none
package gtfr_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 7;

    typedef enum logic [2:0] {
        CMD_LOAD_GLYPH = 3'd0,
        CMD_LOAD_BYTE  = 3'd1,
        CMD_BEGIN      = 3'd2,
        CMD_DRAW       = 3'd3,
        CMD_CONTINUE   = 3'd4,
        CMD_END        = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_WINDOW = 3'd0,
        KIND_PIXEL  = 3'd1,
        KIND_BLANK  = 3'd2,
        KIND_DONE   = 3'd3,
        KIND_BAD    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        REG_START_X    = 3'd0,
        REG_START_Y    = 3'd1,
        REG_FIRST_CODE = 3'd2,
        REG_INK        = 3'd3,
        REG_PAPER      = 3'd4
    } reg_idx_t;

    // output phase of a character after its window
    typedef enum logic [1:0] {
        PH_PIX  = 2'd0,
        PH_BLKX = 2'd1,
        PH_BLKY = 2'd2,
        PH_NONE = 2'd3
    } ph_t;

    typedef struct packed {
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [7:0]  first_code;
        logic [15:0] ink_colour;
        logic [15:0] paper_colour;
    } cfg_t;

    typedef struct packed {
        logic [15:0] start;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [7:0]  advance;
    } glyph_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [6:0]  glyph_slot;
        logic [11:0] glyph_bitmap_start;
        logic [7:0]  glyph_width;
        logic [7:0]  glyph_height;
        logic [7:0]  advance;
        logic [11:0] store_address;
        logic [7:0]  store_byte;
        logic [7:0]  char_code;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] x_left;
        logic [15:0] y_top;
        logic [15:0] x_right;
        logic [15:0] y_bottom;
        logic [15:0] colour;
        logic        last;
    } out_beat_t;

    // skip phases that produce nothing
    function automatic ph_t settle(input ph_t p_in, input logic [7:0] w, input logic [7:0] h,
                                   input logic [7:0] row, input logic [7:0] ow,
                                   input logic [7:0] oh);
        ph_t p;
        begin
            p = p_in;
            if (p == PH_PIX && (w == 8'd0 || row >= h)) p = PH_BLKX;
            if (p == PH_BLKX && !(ow > w)) p = PH_BLKY;
            if (p == PH_BLKY && !(oh > h)) p = PH_NONE;
            return p;
        end
    endfunction

endpackage
`default_nettype wire

### src/gtfr_if.sv
// Valid/ready stream interfaces for command beats and result beats.
// Depends on gtfr_pkg.
`default_nettype none
interface gtfr_in_if;
    import gtfr_pkg::*;
    logic     valid;
    logic     ready;
    in_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gtfr_out_if;
    import gtfr_pkg::*;
    logic      valid;
    logic      ready;
    out_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/glyph_text_field_renderer.sv
// Top level of the glyph text field renderer: configuration registers and
// the render engine. Depends on gtfr_pkg, gtfr_if, gtfr_engine.
//
// Takes one command beat at a time on in_ch and returns RGB565 result beats
// on out_ch. Load commands and begin string are handled in S_IDLE. A draw
// char first reads the glyph table twice (new glyph, then the glyph that the
// previous string held at this position), then gives one result per cycle
// while the output is free; a bitmap byte fetch (S_FETCH, then S_LOAD) comes
// before every eight pixels, and a full run holds 64 results. The bitmap
// store's single registered read port sets the cost of each fetch. End string
// sweeps the string code memory, one entry a cycle, before its done beat.
// Output stalls hold the engine in place; the input is taken again once every
// result of the previous command has been loaded into the output register.
`default_nettype none
module glyph_text_field_renderer
    import gtfr_pkg::*;
#(
    parameter int GLYPH_SLOTS  = 128,
    parameter int BITMAP_BYTES = 4096,
    parameter int STRING_MAX   = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    gtfr_in_if.sink          in_ch,
    gtfr_out_if.source       out_ch
);

    cfg_t cfg_reg;

    // register file; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_x      <= 16'd0;
            cfg_reg.start_y      <= 16'd0;
            cfg_reg.first_code   <= 8'd32;
            cfg_reg.ink_colour   <= 16'hFD20;
            cfg_reg.paper_colour <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_X:    cfg_reg.start_x      <= cfg_data;
                REG_START_Y:    cfg_reg.start_y      <= cfg_data;
                REG_FIRST_CODE: cfg_reg.first_code   <= cfg_data[7:0];
                REG_INK:        cfg_reg.ink_colour   <= cfg_data;
                REG_PAPER:      cfg_reg.paper_colour <= cfg_data;
                default: ;
            endcase
        end
    end

    gtfr_engine #(
        .GLYPH_SLOTS  (GLYPH_SLOTS),
        .BITMAP_BYTES (BITMAP_BYTES),
        .STRING_MAX   (STRING_MAX)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule
`default_nettype wire

### src/gtfr_engine.sv
// Render engine: glyph table, bitmap store and string code memories,
// command sequencer and output register. Depends on gtfr_pkg, gtfr_if.
`default_nettype none
module gtfr_engine
    import gtfr_pkg::*;
#(
    parameter int GLYPH_SLOTS  = 128,
    parameter int BITMAP_BYTES = 4096,
    parameter int STRING_MAX   = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    gtfr_in_if.sink     in_ch,
    gtfr_out_if.source  out_ch
);

    localparam int SLOT_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
    localparam int BM_W   = $clog2(BITMAP_BYTES);
    localparam int SI_W   = (STRING_MAX > 1) ? $clog2(STRING_MAX) : 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD1   = 9'b000000010,
        S_RD2   = 9'b000000100,
        S_WIN   = 9'b000001000,
        S_FETCH = 9'b000010000,
        S_LOAD  = 9'b000100000,
        S_EMIT  = 9'b001000000,
        S_ONE   = 9'b010000000,
        S_COPY  = 9'b100000000
    } state_t;

    // address modulo BITMAP_BYTES; quotient is below 64
    function automatic logic [BM_W-1:0] bm_mod(input logic [11:0] a);
        logic [23:0] v;
        begin
            v = 24'(a);
            for (int k = 5; k >= 0; k--) begin
                if (v >= (24'(BITMAP_BYTES) << k)) v = v - (24'(BITMAP_BYTES) << k);
            end
            return BM_W'(v);
        end
    endfunction

    // memories
    glyph_t      gmem [GLYPH_SLOTS];
    logic [7:0]  bmem [BITMAP_BYTES];
    logic [7:0]  fmem [STRING_MAX];
    logic [7:0]  pmem [STRING_MAX];

    glyph_t            g_rdata;
    logic [7:0]        b_rdata, f_rdata, p_rdata;
    logic              g_we, g_re, b_we, b_re, f_we, f_re, p_re;
    logic [SLOT_W-1:0] g_waddr, g_raddr;
    glyph_t            g_wdata;
    logic [BM_W-1:0]   b_waddr, b_raddr;
    logic [SI_W-1:0]   f_waddr, f_raddr, p_raddr;

    // control and working registers
    state_t           state_reg, state_next;
    logic             busy_reg, busy_next;
    ph_t              ph_reg, ph_next;
    logic [7:0]       pos_reg, pos_next;
    logic [15:0]      cursor_reg, cursor_next;
    logic [CNT_W-1:0] plen_reg, plen_next;
    logic [15:0]      cx_reg, cx_next, cy_reg, cy_next;
    logic [7:0]       cw_reg, cw_next, ch_reg, ch_next, ow_reg, ow_next, oh_reg, oh_next;
    logic [BM_W-1:0]  ra_reg, ra_next;
    logic [7:0]       row_reg, row_next, col_reg, col_next, shift_reg, shift_next;
    logic [2:0]       bc_reg, bc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       code_reg, code_next;
    logic             pok_reg, pok_next, ook_reg, ook_next;
    logic [CNT_W-1:0] ci_reg, ci_next, cn_reg, cn_next;
    logic             copy_we_reg, copy_we_next;
    logic [SI_W-1:0]  copy_wa_reg, copy_wa_next;
    kind_t            one_kind_reg, one_kind_next;
    logic             ov_reg, ov_next;
    out_beat_t        od_reg, od_next;

    logic             accept, out_free;
    logic [7:0]       slot, ps;
    logic [8:0]       col1;
    logic [7:0]       row_n, col_n, mx;
    ph_t              ph_n;
    logic [CNT_W-1:0] cnt1;

    always_ff @(posedge clk)
    begin
        if (g_we) gmem[g_waddr] <= g_wdata;
        if (g_re) g_rdata <= gmem[g_raddr];
        if (b_we) bmem[b_waddr] <= in_ch.data.store_byte;
        if (b_re) b_rdata <= bmem[b_raddr];
        if (f_we) fmem[f_waddr] <= code_reg;
        if (f_re) f_rdata <= fmem[f_raddr];
        if (copy_we_reg) pmem[copy_wa_reg] <= f_rdata;
        if (p_re) p_rdata <= pmem[p_raddr];
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_free     = !ov_reg || out_ch.ready;
    assign out_ch.valid = ov_reg;
    assign out_ch.data  = od_reg;

    always_comb
    begin
        state_next = state_reg; busy_next = busy_reg; ph_next = ph_reg;
        pos_next = pos_reg; cursor_next = cursor_reg; plen_next = plen_reg;
        cx_next = cx_reg; cy_next = cy_reg; cw_next = cw_reg; ch_next = ch_reg;
        ow_next = ow_reg; oh_next = oh_reg; ra_next = ra_reg;
        row_next = row_reg; col_next = col_reg; shift_next = shift_reg; bc_next = bc_reg;
        cnt_next = cnt_reg; code_next = code_reg; pok_next = pok_reg; ook_next = ook_reg;
        ci_next = ci_reg; cn_next = cn_reg; copy_we_next = 1'b0; copy_wa_next = copy_wa_reg;
        one_kind_next = one_kind_reg;
        ov_next = ov_reg && !out_ch.ready;
        od_next = od_reg;

        g_we = 1'b0; g_re = 1'b0; b_we = 1'b0; b_re = 1'b0;
        f_we = 1'b0; f_re = 1'b0; p_re = 1'b0;
        g_waddr = SLOT_W'(in_ch.data.glyph_slot);
        g_wdata = '{start: 16'(bm_mod(in_ch.data.glyph_bitmap_start)),
                    width: in_ch.data.glyph_width, height: in_ch.data.glyph_height,
                    advance: in_ch.data.advance};
        b_waddr = bm_mod(in_ch.data.store_address);
        slot    = in_ch.data.char_code - cfg.first_code;
        ps      = p_rdata - cfg.first_code;
        g_raddr = SLOT_W'(slot);
        b_raddr = ra_reg;
        f_waddr = SI_W'(pos_reg);
        f_raddr = SI_W'(ci_reg);
        p_raddr = SI_W'(pos_reg);
        col1 = 9'(col_reg) + 9'd1;
        row_n = row_reg; col_n = col_reg; mx = 8'd0;
        ph_n = PH_NONE;
        cnt1 = cnt_reg + CNT_W'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_ch.data.command)
                        CMD_LOAD_GLYPH:
                            g_we = (9'(in_ch.data.glyph_slot) < 9'(GLYPH_SLOTS)) ? 1'b1 : 1'b0;
                        CMD_LOAD_BYTE:
                            b_we = 1'b1;
                        CMD_BEGIN:
                        begin
                            busy_next = 1'b0; pos_next = 8'd0; cursor_next = cfg.start_x;
                        end
                        CMD_DRAW:
                        begin
                            if (!busy_reg)
                            begin
                                if (9'(slot) >= 9'(GLYPH_SLOTS))
                                begin
                                    one_kind_next = KIND_BAD;
                                    state_next = S_ONE;
                                end
                                else
                                begin
                                    g_re = 1'b1; p_re = 1'b1;
                                    code_next = in_ch.data.char_code;
                                    pok_next = (7'(pos_reg) < plen_reg || pos_reg[7])
                                               ? ((pos_reg < 8'(plen_reg)) &&
                                                  (pos_reg < 8'(STRING_MAX)))
                                               : 1'b0;
                                    state_next = S_RD1;
                                end
                            end
                        end
                        CMD_CONTINUE:
                        begin
                            if (busy_reg)
                            begin
                                cnt_next = '0;
                                state_next = (ph_reg == PH_PIX && bc_reg == 3'd0) ? S_FETCH
                                                                                  : S_EMIT;
                            end
                        end
                        CMD_END:
                        begin
                            busy_next = 1'b0;
                            cn_next = (pos_reg < 8'(STRING_MAX)) ? CNT_W'(pos_reg)
                                                                 : CNT_W'(STRING_MAX);
                            ci_next = '0;
                            state_next = S_COPY;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD1:
            begin
                cw_next = g_rdata.width; ch_next = g_rdata.height;
                ra_next = BM_W'(g_rdata.start);
                cx_next = cursor_reg; cy_next = cfg.start_y;
                cursor_next = cursor_reg + 16'(g_rdata.advance);
                if (pos_reg < 8'(STRING_MAX)) f_we = 1'b1;
                if (pos_reg != 8'd255) pos_next = pos_reg + 8'd1;
                g_raddr = SLOT_W'(ps);
                ook_next = pok_reg && (9'(ps) < 9'(GLYPH_SLOTS));
                g_re = 1'b1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                ow_next = ook_reg ? g_rdata.width : 8'd0;
                oh_next = ook_reg ? g_rdata.height : 8'd0;
                row_next = 8'd0; col_next = 8'd0; shift_next = 8'd0; bc_next = 3'd0;
                state_next = S_WIN;
            end
            S_WIN:
            begin
                if (out_free)
                begin
                    ph_n = settle(PH_PIX, cw_reg, ch_reg, 8'd0, ow_reg, oh_reg);
                    ov_next = 1'b1;
                    od_next = '{kind: KIND_WINDOW, x_left: cx_reg, y_top: cy_reg,
                                x_right: cx_reg + 16'(cw_reg) - 16'd1,
                                y_bottom: cy_reg + 16'(ch_reg) - 16'd1,
                                colour: 16'd0, last: (ph_n == PH_NONE)};
                    ph_next = ph_n;
                    busy_next = (ph_n != PH_NONE);
                    cnt_next = CNT_W'(1);
                    if (ph_n == PH_NONE) state_next = S_IDLE;
                    else if (ph_n == PH_PIX) state_next = S_FETCH;
                    else state_next = S_EMIT;
                end
            end
            S_FETCH:
            begin
                b_re = 1'b1;
                ra_next = (ra_reg == BM_W'(BITMAP_BYTES - 1)) ? '0 : ra_reg + BM_W'(1);
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                shift_next = b_rdata;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    case (ph_reg)
                        PH_PIX:
                        begin
                            if (col1 >= 9'(cw_reg))
                            begin
                                col_n = 8'd0; row_n = row_reg + 8'd1;
                            end
                            else
                            begin
                                col_n = col1[7:0];
                            end
                            ph_n = settle(PH_PIX, cw_reg, ch_reg, row_n, ow_reg, oh_reg);
                            od_next = '{kind: KIND_PIXEL,
                                        x_left: cx_reg + 16'(col_reg),
                                        y_top: cy_reg + 16'(row_reg),
                                        x_right: cx_reg + 16'(col_reg),
                                        y_bottom: cy_reg + 16'(row_reg),
                                        colour: shift_reg[7] ? cfg.ink_colour
                                                             : cfg.paper_colour,
                                        last: (ph_n == PH_NONE)};
                            col_next = col_n; row_next = row_n;
                            shift_next = {shift_reg[6:0], 1'b0};
                            bc_next = bc_reg + 3'd1;
                        end
                        PH_BLKX:
                        begin
                            mx = (oh_reg > ch_reg) ? oh_reg : ch_reg;
                            ph_n = settle(PH_BLKY, cw_reg, ch_reg, row_reg, ow_reg, oh_reg);
                            od_next = '{kind: KIND_BLANK, x_left: cx_reg + 16'(cw_reg),
                                        y_top: cy_reg,
                                        x_right: cx_reg + 16'(ow_reg) - 16'd1,
                                        y_bottom: cy_reg + 16'(mx) - 16'd1,
                                        colour: cfg.paper_colour, last: (ph_n == PH_NONE)};
                        end
                        default:
                        begin
                            mx = (ow_reg > cw_reg) ? ow_reg : cw_reg;
                            ph_n = PH_NONE;
                            od_next = '{kind: KIND_BLANK, x_left: cx_reg,
                                        y_top: cy_reg + 16'(ch_reg),
                                        x_right: cx_reg + 16'(mx) - 16'd1,
                                        y_bottom: cy_reg + 16'(oh_reg) - 16'd1,
                                        colour: cfg.paper_colour, last: 1'b1};
                        end
                    endcase
                    ph_next = ph_n;
                    cnt_next = cnt1;
                    if (ph_n == PH_NONE)
                    begin
                        busy_next = 1'b0;
                        state_next = S_IDLE;
                    end
                    else if (cnt1 == CNT_W'(MAX_RESULTS))
                        state_next = S_IDLE;
                    else if (ph_n == PH_PIX && bc_next == 3'd0)
                        state_next = S_FETCH;
                end
            end
            S_ONE:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    od_next = '{kind: one_kind_reg, x_left: 16'd0, y_top: 16'd0,
                                x_right: 16'd0, y_bottom: 16'd0, colour: 16'd0, last: 1'b1};
                    state_next = S_IDLE;
                end
            end
            S_COPY:
            begin
                if (ci_reg < cn_reg)
                begin
                    f_re = 1'b1;
                    copy_we_next = 1'b1;
                    copy_wa_next = SI_W'(ci_reg);
                    ci_next = ci_reg + CNT_W'(1);
                end
                else
                begin
                    plen_next = cn_reg;
                    one_kind_next = KIND_DONE;
                    state_next = S_ONE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; busy_reg <= 1'b0; ph_reg <= PH_NONE;
            pos_reg <= 8'd0; cursor_reg <= 16'd0; plen_reg <= '0;
            ra_reg <= '0; row_reg <= 8'd0; col_reg <= 8'd0; shift_reg <= 8'd0;
            bc_reg <= 3'd0; cnt_reg <= '0; ci_reg <= '0; cn_reg <= '0;
            copy_we_reg <= 1'b0; ov_reg <= 1'b0; one_kind_reg <= KIND_DONE;
        end
        else
        begin
            state_reg <= state_next; busy_reg <= busy_next; ph_reg <= ph_next;
            pos_reg <= pos_next; cursor_reg <= cursor_next; plen_reg <= plen_next;
            ra_reg <= ra_next; row_reg <= row_next; col_reg <= col_next;
            shift_reg <= shift_next; bc_reg <= bc_next; cnt_reg <= cnt_next;
            ci_reg <= ci_next; cn_reg <= cn_next; copy_we_reg <= copy_we_next;
            ov_reg <= ov_next; one_kind_reg <= one_kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next; cy_reg <= cy_next; cw_reg <= cw_next; ch_reg <= ch_next;
        ow_reg <= ow_next; oh_reg <= oh_next; code_reg <= code_next;
        pok_reg <= pok_next; ook_reg <= ook_next; copy_wa_reg <= copy_wa_next;
        od_reg <= od_next;
    end

    // a pixel beat is a one-by-one rectangle
    a_pixel_square: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && od_reg.kind == KIND_PIXEL) |->
            (od_reg.x_left == od_reg.x_right && od_reg.y_top == od_reg.y_bottom))
        else $error("pixel beat is not a single point");

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT || state_reg == S_FETCH) |-> busy_reg)
        else $error("emitting with no character in flight");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("result count over limit");

    a_copy_src: assert property (@(posedge clk) disable iff (!rst_n)
        copy_we_reg |-> $past(state_reg == S_COPY))
        else $error("code copy write outside copy sweep");

endmodule
`default_nettype wire
